[sv/species_momentum_accumulator_core_macros.svh]
// assertion macros shared by the accumulator rtl
`ifndef SPECIES_MOMENTUM_ACCUMULATOR_CORE_MACROS_SVH
`define SPECIES_MOMENTUM_ACCUMULATOR_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SMACC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SMACC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/smacc_pkg.sv]
// shared constants, types and saturating helpers of the momentum accumulator
package smacc_pkg;

  localparam int NUM_SPECIES_DEF = 8;
  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 232;
  localparam int D_W        = 63;
  localparam int G_W        = 32;

  typedef struct packed {
    logic           start;
    logic [D_W-1:0] d;
  } gamma_req_t;

  typedef struct packed {
    logic           done;
    logic [G_W-1:0] g;
  } gamma_rsp_t;

  localparam logic [63:0] S64_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      sat_add = a[63] ? S64_MIN : S64_MAX;
    end else begin
      sat_add = s;
    end
  endfunction

  function automatic logic [63:0] from_mag(input logic neg, input logic [63:0] m);
    if (neg) begin
      from_mag = m[63] ? S64_MIN : (64'd0 - m);
    end else begin
      from_mag = m[63] ? S64_MAX : m;
    end
  endfunction

endpackage

[sv/smacc_gamma.sv]
// lorentz factor unit: bit-serial divide of 2^110 by d, then bit-serial square root
module smacc_gamma (
  input  logic                  clk,
  input  logic                  rst_n,
  input  smacc_pkg::gamma_req_t req,
  output smacc_pkg::gamma_rsp_t rsp
);

  typedef enum logic [1:0] {G_IDLE, G_DIV, G_SQRT} gstate_t;

  gstate_t                    state_r;
  logic [5:0]                 cnt_r;
  logic [smacc_pkg::D_W-1:0]  d_r;
  logic [62:0]                rem_r;
  logic [63:0]                q_r;
  logic [smacc_pkg::G_W-1:0]  g_r;
  logic [63:0]                gsq_r;
  logic                       done_r;

  logic [63:0] rem2;
  logic [65:0] t2;
  logic [6:0]  sh1;

  assign rem2 = {rem_r, 1'b0};
  assign sh1  = {1'b0, cnt_r} + 7'd1;
  assign t2   = {2'b0, gsq_r} + ({34'd0, g_r} << sh1) + (66'd1 << {cnt_r, 1'b0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= G_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        G_IDLE: begin
          if (req.start) begin
            d_r <= req.d;
            // quotient of 2^64 or more: root saturates
            if (req.d <= (63'd1 << 46)) begin
              g_r    <= '1;
              done_r <= 1'b1;
            end else begin
              rem_r   <= 63'd1 << 46;
              q_r     <= '0;
              cnt_r   <= 6'd63;
              state_r <= G_DIV;
            end
          end
        end
        G_DIV: begin
          if (rem2 >= {1'b0, d_r}) begin
            rem_r <= 63'(rem2 - {1'b0, d_r});
            q_r   <= {q_r[62:0], 1'b1};
          end else begin
            rem_r <= rem2[62:0];
            q_r   <= {q_r[62:0], 1'b0};
          end
          if (cnt_r == 6'd0) begin
            g_r     <= '0;
            gsq_r   <= '0;
            cnt_r   <= 6'd31;
            state_r <= G_SQRT;
          end else begin
            cnt_r <= cnt_r - 6'd1;
          end
        end
        G_SQRT: begin
          if (t2 <= {2'b0, q_r}) begin
            g_r   <= g_r | (32'd1 << cnt_r[4:0]);
            gsq_r <= t2[63:0];
          end
          if (cnt_r == 6'd0) begin
            done_r  <= 1'b1;
            state_r <= G_IDLE;
          end else begin
            cnt_r <= cnt_r - 6'd1;
          end
        end
        default: state_r <= G_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.g    = g_r;

endmodule

[sv/species_momentum_accumulator_core.sv]
// species momentum accumulator top level: sequencer, shared multiplier, sum memory
//
//  channel | ports                 | carries
//  --------+-----------------------+-----------------------------------------------
//  in      | in_tvalid/tready/...  | one particle (cmd 0) or a report request (cmd 1)
//  out     | out_tvalid/tready/... | one momentum vector per species, then the total
//  cfg     | cfg_wen, cfg_wdata    | relativistic mode bit
//
// accumulate: the one 32x32 multiplier serves every step; relativistic mode adds the gamma
// unit's divide and square root (skipped if gamma saturates); a superluminal particle stops
// after the speed check; report: species vectors then the total, held back if out stalls
// a particle with an out-of-range species is dropped in the accept cycle
// reset clears the per-species valid bits, so sums read as zero without a sweep
// in_tready is low for the whole time an item is being worked on
`include "species_momentum_accumulator_core_macros.svh"

module species_momentum_accumulator_core #(
  parameter int NUM_SPECIES = smacc_pkg::NUM_SPECIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: species[2:0], mass[18:3], weight[34:19], beta_x[66:35],
  //           beta_y[98:67], beta_z[130:99], zero fill
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [smacc_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                             in_tuser,   // cmd
  // out_tdata: species_out[2:0], mom_x[66:3], mom_y[130:67], mom_z[194:131],
  //            rejected[226:195], zero fill
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [smacc_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                             out_tuser,  // is_total
  output logic                             out_tlast,  // last
  input  logic                             cfg_wen,
  input  logic                             cfg_wdata   // relativistic
);

  localparam int SW  = (NUM_SPECIES > 1) ? $clog2(NUM_SPECIES) : 1;
  localparam int MD  = NUM_SPECIES * 3;
  localparam int AW  = (MD > 1) ? $clog2(MD) : 1;
  localparam logic [SW-1:0] ROW_LAST = SW'(NUM_SPECIES - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MW, S_SQ, S_SQL, S_CHK, S_GAM, S_MM, S_GLO, S_GHI, S_GSC, S_ACC,
    S_RRD, S_RCAP, S_ROUT, S_RTOT
  } state_t;

  state_t                 state_r;
  logic                   rel_r;
  logic [SW-1:0]          row_r;
  logic [1:0]             c_r;
  logic [15:0]            mass_r, weight_r;
  logic [31:0]            mag_r [3];
  logic [2:0]             neg_r;
  logic [31:0]            mw_r;
  logic [63:0]            b2_r;
  logic [63:0]            prod_r;
  logic [63:0]            m_r;
  logic [63:0]            lo_r;
  logic [31:0]            g_r;
  logic [31:0]            rej_r;
  logic [NUM_SPECIES-1:0] vld_r;
  logic [63:0]            vec_r [3];
  logic [63:0]            tot_r [3];
  logic [63:0]            rd_r;
  logic [63:0]            mem [MD];

  logic                            out_tvalid_r, out_tuser_r, out_tlast_r;
  logic [smacc_pkg::OUT_DATA_W-1:0] out_tdata_r;

  smacc_pkg::gamma_req_t gam_req;
  smacc_pkg::gamma_rsp_t gam_rsp;

  logic        in_fire, out_free, out_load, mul_en, mem_we;
  logic [31:0] mul_a, mul_b;
  logic [31:0] species32, addr32, bx, by, bz;
  logic [AW-1:0] addr;
  logic [95:0] psum;
  logic [63:0] mval, old_val, sum_val;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  // a new vector goes into the out register this cycle
  assign out_load  = out_free && ((state_r == S_ROUT) || (state_r == S_RTOT));

  assign species32 = {29'd0, in_tdata[2:0]};
  assign bx        = in_tdata[66:35];
  assign by        = in_tdata[98:67];
  assign bz        = in_tdata[130:99];

  assign addr32 = (32'(row_r) * 32'd3) + {30'd0, c_r};
  assign addr   = addr32[AW-1:0];

  // shared multiplier operand select
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_r)
      S_MW: begin
        mul_a = {16'd0, mass_r};
        mul_b = {16'd0, weight_r};
      end
      S_SQ: begin
        mul_a = mag_r[c_r];
        mul_b = mag_r[c_r];
      end
      S_MM: begin
        mul_a = mw_r;
        mul_b = mag_r[c_r];
      end
      S_GLO: begin
        mul_a = prod_r[31:0];
        mul_b = g_r;
      end
      S_GHI: begin
        mul_a = m_r[63:32];
        mul_b = g_r;
      end
      default: mul_en = 1'b0;
    endcase
  end

  // gamma scaling with round half up on the magnitude
  assign psum    = {prod_r, 32'd0} + {32'd0, lo_r} + (96'd1 << 23);
  assign mval    = rel_r ? m_r : prod_r;
  assign old_val = vld_r[row_r] ? rd_r : 64'd0;
  assign sum_val = smacc_pkg::sat_add(old_val,
                     smacc_pkg::from_mag(neg_r[c_r] && (mval != 64'd0), mval));
  assign mem_we  = (state_r == S_ACC);

  assign gam_req.start = (state_r == S_CHK) && (b2_r < (64'd1 << 62)) && rel_r;
  assign gam_req.d     = 63'(64'd1 << 62) - b2_r[62:0];

  smacc_gamma u_gamma (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (gam_req),
    .rsp   (gam_rsp)
  );

  // momentum sum memory, one component per word
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= sum_val;
    end
    rd_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= 64'(mul_a) * 64'(mul_b);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rel_r        <= 1'b0;
      rej_r        <= '0;
      vld_r        <= '0;
      out_tvalid_r <= 1'b0;
      c_r          <= '0;
    end else begin
      if (cfg_wen) begin
        rel_r <= cfg_wdata;
      end
      if (out_tvalid_r && out_tready && !out_load) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            c_r <= 2'd0;
            if (in_tuser) begin
              // report request
              row_r    <= '0;
              tot_r[0] <= '0;
              tot_r[1] <= '0;
              tot_r[2] <= '0;
              state_r  <= S_RRD;
            end else if (species32 < 32'(NUM_SPECIES)) begin
              row_r    <= species32[SW-1:0];
              mass_r   <= in_tdata[18:3];
              weight_r <= in_tdata[34:19];
              neg_r    <= {bz[31], by[31], bx[31]};
              mag_r[0] <= bx[31] ? (32'd0 - bx) : bx;
              mag_r[1] <= by[31] ? (32'd0 - by) : by;
              mag_r[2] <= bz[31] ? (32'd0 - bz) : bz;
              b2_r     <= '0;
              state_r  <= S_MW;
            end
          end
        end
        S_MW: state_r <= S_SQ;
        S_SQ: begin
          if (c_r == 2'd0) begin
            mw_r <= prod_r[31:0];
          end else begin
            b2_r <= b2_r + prod_r;
          end
          if (c_r == 2'd2) begin
            c_r     <= 2'd0;
            state_r <= S_SQL;
          end else begin
            c_r <= c_r + 2'd1;
          end
        end
        S_SQL: begin
          b2_r    <= b2_r + prod_r;
          state_r <= S_CHK;
        end
        S_CHK: begin
          if (b2_r >= (64'd1 << 62)) begin
            // superluminal particle
            if (rej_r != '1) begin
              rej_r <= rej_r + 32'd1;
            end
            state_r <= S_IDLE;
          end else if (rel_r) begin
            state_r <= S_GAM;
          end else begin
            state_r <= S_MM;
          end
        end
        S_GAM: begin
          if (gam_rsp.done) begin
            g_r     <= gam_rsp.g;
            state_r <= S_MM;
          end
        end
        S_MM: state_r <= rel_r ? S_GLO : S_ACC;
        S_GLO: begin
          m_r     <= prod_r;
          state_r <= S_GHI;
        end
        S_GHI: begin
          lo_r    <= prod_r;
          state_r <= S_GSC;
        end
        S_GSC: begin
          m_r     <= (psum[95:88] != 8'd0) ? 64'hffff_ffff_ffff_ffff : psum[87:24];
          state_r <= S_ACC;
        end
        S_ACC: begin
          if (c_r == 2'd2) begin
            vld_r[row_r] <= 1'b1;
            c_r          <= 2'd0;
            state_r      <= S_IDLE;
          end else begin
            c_r     <= c_r + 2'd1;
            state_r <= S_MM;
          end
        end
        S_RRD: begin
          if (c_r != 2'd0) begin
            vec_r[c_r - 2'd1] <= old_val;
          end
          if (c_r == 2'd2) begin
            state_r <= S_RCAP;
          end else begin
            c_r <= c_r + 2'd1;
          end
        end
        S_RCAP: begin
          vec_r[2] <= old_val;
          state_r  <= S_ROUT;
        end
        S_ROUT: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_tuser_r  <= 1'b0;
            out_tlast_r  <= 1'b0;
            out_tdata_r  <= {5'd0, 32'd0, vec_r[2], vec_r[1], vec_r[0],
                             3'(32'(row_r))};
            tot_r[0]     <= smacc_pkg::sat_add(tot_r[0], vec_r[0]);
            tot_r[1]     <= smacc_pkg::sat_add(tot_r[1], vec_r[1]);
            tot_r[2]     <= smacc_pkg::sat_add(tot_r[2], vec_r[2]);
            c_r          <= 2'd0;
            if (row_r == ROW_LAST) begin
              state_r <= S_RTOT;
            end else begin
              row_r   <= row_r + SW'(1);
              state_r <= S_RRD;
            end
          end
        end
        S_RTOT: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_tuser_r  <= 1'b1;
            out_tlast_r  <= 1'b1;
            out_tdata_r  <= {5'd0, rej_r, tot_r[2], tot_r[1], tot_r[0], 3'd0};
            // clear sums and count for the next interval
            vld_r        <= '0;
            rej_r        <= '0;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  `SMACC_ASSERT_IMP(a_last_is_total, out_tvalid && out_tlast, out_tuser,
                    "last transfer is not the total")
  `SMACC_ASSERT_IMP(a_gamma_in_wait, gam_rsp.done, state_r == S_GAM,
                    "gamma result outside wait state")
  `SMACC_ASSERT_NXT(a_report_clears, state_r == S_RTOT && out_free,
                    vld_r == '0 && rej_r == '0, "sums not cleared after report")

endmodule

[sim/species_momentum_accumulator_core_test.sv]
// testbench for the species momentum accumulator: directed table, then random traffic
`timescale 1ns / 1ps

module species_momentum_accumulator_core_test;

  localparam int NSPEC = smacc_pkg::NUM_SPECIES_DEF;
  localparam logic CMD_ACC = 1'b0;
  localparam logic CMD_REPORT = 1'b1;
  localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;

  // one particle or report request
  typedef struct packed {
    logic        cmd;
    logic [2:0]  species;
    logic [15:0] mass;
    logic [15:0] weight;
    logic [31:0] bx;
    logic [31:0] by;
    logic [31:0] bz;
  } particle_t;

  // one emitted momentum vector
  typedef struct packed {
    logic        is_total;
    logic [2:0]  species;
    logic [63:0] px;
    logic [63:0] py;
    logic [63:0] pz;
    logic [31:0] rejected;
    logic        last;
  } momentum_t;

  // directed row: optional mode write ahead of the item
  typedef struct packed {
    logic      cfg_write;
    logic      cfg_value;
    particle_t item;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [smacc_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [smacc_pkg::OUT_DATA_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;
  logic cfg_wen = 1'b0;
  logic cfg_wdata = 1'b0;

  always #5 clk = ~clk;

  species_momentum_accumulator_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
  );

  // predictor state
  logic [63:0] sums [NSPEC][3];
  logic [31:0] reject_count;
  logic        rel_mode;
  momentum_t   pending_vectors [$];
  momentum_t   typed_v;

  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;
  int phase = -1;
  bit hold_done = 1'b0;

  // largest g with g*g*d <= 2^110
  function automatic logic [31:0] lorentz_q24(input logic [63:0] d);
    logic [31:0] g;
    logic [31:0] t;
    logic [127:0] p;
    g = '0;
    for (int b = 31; b >= 0; b--) begin
      t = g | (32'd1 << b);
      p = 128'(t) * 128'(t) * 128'(d);
      if (p <= (128'd1 << 110)) g = t;
    end
    return g;
  endfunction

  function automatic logic [63:0] gamma_scaled(input logic [63:0] m, input logic [31:0] g);
    logic [127:0] p;
    p = 128'(m) * 128'(g) + (128'd1 << 23);
    p = p >> 24;
    return (p[127:64] != 0) ? 64'hffff_ffff_ffff_ffff : p[63:0];
  endfunction

  task automatic predict_item(input particle_t it);
    logic [63:0] mw;
    logic [63:0] mag [3];
    logic        neg [3];
    logic [31:0] comp [3];
    logic [65:0] b2;
    logic [31:0] g;
    logic [63:0] m;
    logic [63:0] tot [3];
    momentum_t   v;
    if (it.cmd == CMD_ACC) begin
      if (int'(it.species) >= NSPEC) return;
      comp[0] = it.bx; comp[1] = it.by; comp[2] = it.bz;
      mw = 64'(it.mass) * 64'(it.weight);
      b2 = '0;
      for (int c = 0; c < 3; c++) begin
        neg[c] = comp[c][31];
        mag[c] = neg[c] ? (64'h1_0000_0000 - 64'(comp[c])) : 64'(comp[c]);
        b2 += 66'(mag[c] * mag[c]);
      end
      if (b2 >= 66'(ONE_Q62)) begin
        if (reject_count != 32'hffff_ffff) reject_count++;
        return;
      end
      g = rel_mode ? lorentz_q24(ONE_Q62 - b2[63:0]) : 32'd0;
      for (int c = 0; c < 3; c++) begin
        m = mw * mag[c];
        if (rel_mode) m = gamma_scaled(m, g);
        sums[it.species][c] = smacc_pkg::sat_add(sums[it.species][c],
                                smacc_pkg::from_mag(neg[c] && m != 0, m));
      end
    end else begin
      tot = '{default: 64'd0};
      for (int s = 0; s < NSPEC; s++) begin
        v = '0;
        v.species = 3'(s);
        v.px = sums[s][0]; v.py = sums[s][1]; v.pz = sums[s][2];
        for (int c = 0; c < 3; c++) tot[c] = smacc_pkg::sat_add(tot[c], sums[s][c]);
        pending_vectors.push_back(v);
      end
      v = '0;
      v.is_total = 1'b1;
      v.px = tot[0]; v.py = tot[1]; v.pz = tot[2];
      v.rejected = reject_count;
      v.last = 1'b1;
      pending_vectors.push_back(v);
      for (int s = 0; s < NSPEC; s++) sums[s] = '{default: 64'd0};
      reject_count = '0;
    end
  endtask

  // drive one item and wait for its transfer; valid stays up for a following item
  task automatic send_item(input particle_t it, input bit use_model = 1'b1);
    if (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99, 0) < send_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= it.cmd;
    in_tdata <= smacc_pkg::IN_DATA_W'({it.bz, it.by, it.bx, it.weight, it.mass, it.species});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (use_model) predict_item(it);
  endtask

  task automatic write_mode(input logic value);
    // drain, then let a long relativistic accumulate finish
    in_tvalid <= 1'b0;
    while (pending_vectors.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    rel_mode = value;
  endtask

  function automatic particle_t random_particle();
    particle_t it;
    int kind;
    it = '0;
    it.cmd = CMD_ACC;
    it.species = 3'($urandom_range(7, 0));
    it.mass = 16'($urandom);
    it.weight = 16'($urandom);
    kind = $urandom_range(9, 0);
    if (kind < 6) begin
      // sub-light: each component under about 0.57 c
      it.bx = 32'($signed($urandom_range(32'h4900_0000, 0)) * ($urandom_range(1, 0) ? -1 : 1));
      it.by = 32'($signed($urandom_range(32'h4900_0000, 0)) * ($urandom_range(1, 0) ? -1 : 1));
      it.bz = 32'($signed($urandom_range(32'h4900_0000, 0)) * ($urandom_range(1, 0) ? -1 : 1));
    end else if (kind < 8) begin
      // close to c along one axis
      it.bx = $urandom_range(1, 0) ? 32'h7fff_0000 + 32'($urandom_range(65535, 0))
                                   : 32'h8000_0000 + 32'($urandom_range(65535, 0));
      it.by = 32'($urandom_range(255, 0));
      it.bz = 32'($urandom_range(255, 0));
    end else begin
      it.bx = $urandom; it.by = $urandom; it.bz = $urandom;
    end
    return it;
  endfunction

  // out side: stalls and one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (phase == 2 && !hold_done) begin
      hold_done <= 1'b1;
      hold_off <= 400;
      out_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // compare each vector transfer with the oldest expectation
  always @(posedge clk) begin
    momentum_t got;
    momentum_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '0;
      got.is_total = out_tuser;
      got.last = out_tlast;
      got.species = out_tdata[2:0];
      got.px = out_tdata[66:3];
      got.py = out_tdata[130:67];
      got.pz = out_tdata[194:131];
      got.rejected = out_tdata[226:195];
      if (pending_vectors.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected vector transfer %p", got);
      end else begin
        want = pending_vectors.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("vector mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  row_t directed [$];
  particle_t it;

  function automatic row_t mk(input logic cmd, input logic [2:0] sp, input logic [15:0] m,
                              input logic [15:0] w, input logic [31:0] x,
                              input logic [31:0] y, input logic [31:0] z);
    row_t r;
    r = '0;
    r.item = '{cmd, sp, m, w, x, y, z};
    return r;
  endfunction

  initial begin
    #20_000_000;
    $display("species_momentum_accumulator_core_test: FAIL");
    $finish;
  end

  initial begin
    for (int s = 0; s < NSPEC; s++) sums[s] = '{default: 64'd0};
    reject_count = '0;
    rel_mode = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // report right after reset: all zero, checked by value
    for (int s = 0; s < NSPEC; s++) begin
      typed_v = '0;
      typed_v.species = 3'(s);
      pending_vectors.push_back(typed_v);
    end
    typed_v = '0;
    typed_v.is_total = 1'b1;
    typed_v.last = 1'b1;
    pending_vectors.push_back(typed_v);
    send_item('{CMD_REPORT, 3'd5, 16'hffff, 16'hffff, 32'h7fff_ffff, 32'h8000_0000, 32'd1},
              1'b0);
    in_tvalid <= 1'b0;
    while (pending_vectors.size() != 0) @(posedge clk);

    directed.push_back(mk(CMD_ACC, 3'd0, 16'hffff, 16'hffff, 32'h7fff_ffff, 32'd0, 32'd0));
    directed.push_back(mk(CMD_ACC, 3'd0, 16'hffff, 16'hffff, 32'h8000_0001, 32'd0, 32'd0));
    directed.push_back(mk(CMD_ACC, 3'd1, 16'hffff, 16'hffff, 32'h8000_0000, 32'd0,
                          32'd0)); // exactly c
    directed.push_back(mk(CMD_ACC, 3'd2, 16'd0, 16'hffff, 32'h1000_0000, 32'hf000_0000,
                          32'd5));
    directed.push_back(mk(CMD_ACC, 3'd7, 16'h1234, 16'd0, 32'h4000_0000, 32'h4000_0000,
                          32'h4000_0000));
    directed.push_back(mk(CMD_ACC, 3'd3, 16'd1, 16'd1, 32'h5a82_7999, 32'h5a82_7999,
                          32'd0)); // just below c
    directed.push_back(mk(CMD_ACC, 3'd3, 16'd1, 16'd1, 32'h5a82_799a, 32'h5a82_799a,
                          32'd0)); // just above c
    directed.push_back(mk(CMD_ACC, 3'd4, 16'hffff, 16'hffff, 32'hffff_ffff, 32'd1,
                          32'h7000_0000));
    directed.push_back(mk(CMD_REPORT, 3'd0, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0));
    directed.push_back(mk(CMD_ACC, 3'd5, 16'hffff, 16'hffff, 32'h7fff_fff0, 32'd0, 32'd0));
    directed.push_back(mk(CMD_ACC, 3'd6, 16'hffff, 16'hffff, 32'h7fff_fff0, 32'd0, 32'd0));
    directed.push_back(mk(CMD_ACC, 3'd5, 16'd3, 16'd7, 32'h0000_0001, 32'hffff_ffff, 32'd0));
    directed.push_back(mk(CMD_REPORT, 3'd0, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0));
    directed[9].cfg_write = 1'b1;
    directed[9].cfg_value = 1'b1;
    foreach (directed[i]) begin
      if (directed[i].cfg_write) write_mode(directed[i].cfg_value);
      send_item(directed[i].item);
    end
    // repeated near-c particles in relativistic mode push species 5 to saturation
    for (int k = 0; k < 6; k++) send_item(directed[9].item);
    send_item(mk(CMD_REPORT, 3'd0, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0).item);

    // random phases: none, sender idle, receiver stall, both; the mode bit is the phase's low bit
    for (int ph = 0; ph < 8; ph++) begin
      write_mode(ph[0]);
      send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 3) ? 37 : 82) : 0;
      recv_stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? ((ph % 4 == 3) ? 37 : 82) : 0;
      phase = ph;
      for (int n = 0; n < 37; n++) begin
        if ($urandom_range(5, 0) == 0) begin
          it = random_particle();
          it.cmd = CMD_REPORT;
        end else begin
          it = random_particle();
        end
        send_item(it);
      end
      send_item(mk(CMD_REPORT, 3'd0, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0).item);
    end

    in_tvalid <= 1'b0;
    while (pending_vectors.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("species_momentum_accumulator_core_test: PASS");
    end else begin
      $display("species_momentum_accumulator_core_test: FAIL");
    end
    $finish;
  end

endmodule
